/* rtl/core/mac_learning_forwarder_top_macros.svh */
// Assertion macros for the learning forwarder checker.
`ifndef MAC_LEARNING_FORWARDER_TOP_MACROS_SVH
`define MAC_LEARNING_FORWARDER_TOP_MACROS_SVH

// Check a property outside reset.
`define MLF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define MLF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/mlf_pkg.sv */
package mlf_pkg;

  localparam int MAC_W       = 48;
  localparam int PORT_W      = 3;
  localparam int MASK_W      = 8;
  localparam int PCNT_W      = 4;
  localparam int MAX_PORTS   = 8;
  localparam int PORT_LIMIT  = (MAX_PORTS < MASK_W) ? MAX_PORTS : MASK_W;
  localparam logic [PCNT_W-1:0] PORT_COUNT_RST = 4'd8;

  localparam logic [MAC_W-1:0] NULL_MAC  = '0;
  localparam logic [MAC_W-1:0] BCAST_MAC = '1;

  typedef enum logic [1:0] {
    ACT_DROP    = 2'd0,
    ACT_FORWARD = 2'd1,
    ACT_FLOOD   = 2'd2,
    ACT_PROBE   = 2'd3
  } action_t;

  typedef struct packed {
    logic [MAC_W-1:0]  src;
    logic [MAC_W-1:0]  dst;
    logic [PORT_W-1:0] port;
    logic              src_found;
    logic              dst_hit;
    logic [PORT_W-1:0] dst_port;
  } token_t;

endpackage

/* rtl/core/mac_learning_forwarder_top.sv */
// Learning bridge address table with forwarding decision.
// Input: pulse start with in_src_mac, in_dst_mac and in_ingress_port; the
// header beat is taken at any edge where start is high and busy is low.
// busy stays low: the table is a row of TABLE_DEPTH cells and a header moves
// one cell per cycle, so a new header may enter every cycle.
// Path: out_valid comes from the decision register, which follows one register
// per cell, the first loading at the edge that takes the header beat; the
// result beat is taken at the edge after out_valid rises.
// Throughput: one header per cycle, results in the order headers arrived.
// Each cell learns the source at the first free entry it meets, so headers
// in flight see every address learned by the headers ahead of them.
// Results: out_action (drop, forward, flood, probe), out_port_mask and
// out_table_full. The receiver cannot stall; it must take each beat.
// Configuration: cfg_we with cfg_wdata sets the active port count; write it
// only while no header is in flight.
// Reset (rst_n low, synchronous): empties the table, clears in-flight
// headers and sets the port count to 8. No clearing pass is needed.
module mac_learning_forwarder_top #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [mlf_pkg::MAC_W-1:0]     in_src_mac,
  input  logic [mlf_pkg::MAC_W-1:0]     in_dst_mac,
  input  logic [mlf_pkg::PORT_W-1:0]    in_ingress_port,
  input  logic                          cfg_we,
  input  logic [mlf_pkg::PCNT_W-1:0]    cfg_wdata,
  output logic                          out_valid,
  output logic [1:0]                    out_action,
  output logic [mlf_pkg::MASK_W-1:0]    out_port_mask,
  output logic                          out_table_full
);

  logic [mlf_pkg::PCNT_W-1:0] port_count_r;
  logic                       vld  [TABLE_DEPTH+1];
  mlf_pkg::token_t            tok  [TABLE_DEPTH+1];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_count_r <= mlf_pkg::PORT_COUNT_RST;
    end else if (cfg_we) begin
      port_count_r <= cfg_wdata;
    end
  end

  always_comb begin
    vld[0]           = start && !busy;
    tok[0].src       = in_src_mac;
    tok[0].dst       = in_dst_mac;
    tok[0].port      = in_ingress_port;
    tok[0].src_found = 1'b0;
    tok[0].dst_hit   = 1'b0;
    tok[0].dst_port  = '0;
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    mlf_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (vld[i]),
      .tok_i (tok[i]),
      .vld_o (vld[i+1]),
      .tok_o (tok[i+1])
    );
  end

  mlf_decide u_decide (
    .clk            (clk),
    .rst_n          (rst_n),
    .vld_i          (vld[TABLE_DEPTH]),
    .tok_i          (tok[TABLE_DEPTH]),
    .port_count     (port_count_r),
    .out_valid      (out_valid),
    .out_action     (out_action),
    .out_port_mask  (out_port_mask),
    .out_table_full (out_table_full)
  );

endmodule

/* rtl/core/mlf_cell.sv */
module mlf_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            vld_i,
  input  mlf_pkg::token_t tok_i,
  output logic            vld_o,
  output mlf_pkg::token_t tok_o
);

  logic                           entry_vld_r;
  logic [mlf_pkg::MAC_W-1:0]      entry_addr_r;
  logic [mlf_pkg::PORT_W-1:0]     entry_port_r;
  logic                           wr;
  logic                           vld_r;
  mlf_pkg::token_t                tok_r;
  mlf_pkg::token_t                tok_nxt;

  // Look up both addresses; learn the source at the first free entry unless already found.
  always_comb begin
    tok_nxt = tok_i;
    wr      = 1'b0;
    if (vld_i) begin
      if (entry_vld_r) begin
        if (entry_addr_r == tok_i.src) begin
          tok_nxt.src_found = 1'b1;
        end
        if (entry_addr_r == tok_i.dst) begin
          tok_nxt.dst_hit  = 1'b1;
          tok_nxt.dst_port = entry_port_r;
        end
      end else if (!tok_i.src_found) begin
        wr                = 1'b1;
        tok_nxt.src_found = 1'b1;
        if (tok_i.dst == tok_i.src) begin
          tok_nxt.dst_hit  = 1'b1;
          tok_nxt.dst_port = tok_i.port;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_vld_r <= 1'b0;
      vld_r       <= 1'b0;
    end else begin
      vld_r <= vld_i;
      if (wr) begin
        entry_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
    if (wr) begin
      entry_addr_r <= tok_i.src;
      entry_port_r <= tok_i.port;
    end
  end

  assign vld_o = vld_r;
  assign tok_o = tok_r;

endmodule

/* rtl/core/mlf_decide.sv */
module mlf_decide (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          vld_i,
  input  mlf_pkg::token_t               tok_i,
  input  logic [mlf_pkg::PCNT_W-1:0]    port_count,
  output logic                          out_valid,
  output logic [1:0]                    out_action,
  output logic [mlf_pkg::MASK_W-1:0]    out_port_mask,
  output logic                          out_table_full
);

  logic [mlf_pkg::PCNT_W-1:0]   n_ports;
  logic [mlf_pkg::MASK_W-1:0]   active_mask;
  mlf_pkg::action_t             action_nxt;
  logic [mlf_pkg::MASK_W-1:0]   mask_nxt;
  logic                         out_valid_r;
  mlf_pkg::action_t             action_r;
  logic [mlf_pkg::MASK_W-1:0]   mask_r;
  logic                         full_r;

  always_comb begin
    n_ports = (port_count > mlf_pkg::PCNT_W'(mlf_pkg::PORT_LIMIT)) ?
              mlf_pkg::PCNT_W'(mlf_pkg::PORT_LIMIT) : port_count;
    active_mask = mlf_pkg::MASK_W'(((mlf_pkg::MASK_W+1)'(1) << n_ports) -
                                   (mlf_pkg::MASK_W+1)'(1));
    if (tok_i.dst == mlf_pkg::NULL_MAC) begin
      action_nxt = mlf_pkg::ACT_DROP;
      mask_nxt   = '0;
    end else if (tok_i.dst == mlf_pkg::BCAST_MAC) begin
      action_nxt = mlf_pkg::ACT_FLOOD;
      mask_nxt   = active_mask;
    end else if (tok_i.dst_hit) begin
      action_nxt = mlf_pkg::ACT_FORWARD;
      mask_nxt   = mlf_pkg::MASK_W'(1) << tok_i.dst_port;
    end else begin
      action_nxt = mlf_pkg::ACT_PROBE;
      mask_nxt   = active_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    action_r <= action_nxt;
    mask_r   <= mask_nxt;
    full_r   <= !tok_i.src_found;
  end

  assign out_valid      = out_valid_r;
  assign out_action     = action_r;
  assign out_port_mask  = mask_r;
  assign out_table_full = full_r;

endmodule

/* rtl/core/mlf_checker.sv */
`include "mac_learning_forwarder_top_macros.svh"

module mlf_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic [1:0]                    out_action,
  input logic [mlf_pkg::MASK_W-1:0]    out_port_mask
);

  logic [mlf_pkg::MASK_W:0] mask_ext;
  logic                     drop_beat;
  logic                     fwd_beat;
  logic                     flood_beat;
  logic                     mask_contig;

  assign mask_ext    = {1'b0, out_port_mask};
  assign drop_beat   = out_valid && (out_action == mlf_pkg::ACT_DROP);
  assign fwd_beat    = out_valid && (out_action == mlf_pkg::ACT_FORWARD);
  assign flood_beat  = out_valid && (out_action == mlf_pkg::ACT_FLOOD ||
                                     out_action == mlf_pkg::ACT_PROBE);
  assign mask_contig = ((mask_ext + (mlf_pkg::MASK_W+1)'(1)) & mask_ext) == '0;

  `MLF_ASSERT(a_drop_empty, drop_beat |-> (out_port_mask == '0), "drop beat with nonzero mask")
  `MLF_ASSERT(a_fwd_onehot, fwd_beat |-> $onehot(out_port_mask), "forward beat mask not one-hot")
  `MLF_ASSERT(a_flood_low, flood_beat |-> mask_contig, "flood mask not contiguous from port 0")
  `MLF_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !out_valid, "result beat right after reset")

endmodule

bind mac_learning_forwarder_top mlf_checker u_mlf_checker (.*);
